// File: src/rbpp_pkg.sv
// Shared types, widths and helpers for the rounded box point projection unit.
// No dependencies; every other file imports this package.
`default_nettype none

package rbpp_pkg;

	localparam int COORD_W        = 32;
	localparam int CFG_W          = 31;
	localparam int AXES_MAX       = 3;
	localparam int SQ_W           = 64;
	localparam int ROOT_W         = 32;
	localparam int QUO_W          = 31;
	localparam int PROD_W         = CFG_W + COORD_W;
	localparam int ADDR_W         = 4;
	localparam int DATA_W         = 32;
	localparam int DIMENSIONS_DEF = 3;

	typedef enum logic [1:0] {
		REG_HALF_X,
		REG_HALF_Y,
		REG_HALF_Z,
		REG_RADIUS
	} reg_idx_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic [AXES_MAX-1:0][CFG_W-1:0] half_len;
		logic [CFG_W-1:0]               radius;
	} cfg_t;

	// Per-point data carried down the pipeline
	typedef struct packed {
		logic [AXES_MAX-1:0][COORD_W-1:0] w;
		logic [AXES_MAX-1:0]              neg;
		logic [AXES_MAX-1:0]              clamped;
		logic [AXES_MAX-1:0][COORD_W-1:0] m;
		logic                             in_box;
		logic                             in_inner;
		axis_t                            axis;
	} item_t;

	// Inner box half extent, floored at zero
	function automatic logic [CFG_W-1:0] inner_half(input logic [CFG_W-1:0] l,
			input logic [CFG_W-1:0] r);
		return (l > r) ? l - r : '0;
	endfunction

endpackage

`default_nettype wire

// File: src/rbpp_cfg.sv
// APB-style configuration registers: three half extents and the corner radius.
// Depends on rbpp_pkg.
`default_nettype none

module rbpp_cfg import rbpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write on the access phase of a write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_HALF_X: cfg_q.half_len[0] <= pwdata[CFG_W-1:0];
				REG_HALF_Y: cfg_q.half_len[1] <= pwdata[CFG_W-1:0];
				REG_HALF_Z: cfg_q.half_len[2] <= pwdata[CFG_W-1:0];
				REG_RADIUS: cfg_q.radius      <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_HALF_X: prdata = {1'b0, cfg_q.half_len[0]};
			REG_HALF_Y: prdata = {1'b0, cfg_q.half_len[1]};
			REG_HALF_Z: prdata = {1'b0, cfg_q.half_len[2]};
			REG_RADIUS: prdata = {1'b0, cfg_q.radius};
			default:    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: src/rbpp_front.sv
// Front stages: clamp to the inner box, face choice, squares and the inside test.
// Five register stages; depends on rbpp_pkg.
`default_nettype none

module rbpp_front import rbpp_pkg::*; #(
	parameter int DIMENSIONS = DIMENSIONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfg_t                             cfg,
	input  logic                             in_valid,
	input  logic [AXES_MAX-1:0][COORD_W-1:0] in_w,
	output logic                             out_valid,
	output item_t                            out_item,
	output logic [SQ_W-1:0]                  out_s
);

	localparam int AXES = (DIMENSIONS >= 3) ? 3 : 2;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [AXES_MAX-1:0][COORD_W-1:0] w_s1, w_s2, w_s3, w_s4;
	logic [AXES_MAX-1:0]              neg_s2, neg_s3, neg_s4;
	logic [AXES_MAX-1:0]              clamp_s2, clamp_s3, clamp_s4;
	logic [AXES_MAX-1:0]              out_s2;
	logic [AXES_MAX-1:0][COORD_W-1:0] m_s2, m_s3, m_s4;
	logic [AXES_MAX-1:0][COORD_W-1:0] qin_s2, d_s2;
	logic [AXES_MAX-1:0][SQ_W-1:0]    msq_s3, qsq_s3;
	logic [2*CFG_W-1:0]               rsq_s3, rsq_s4;
	axis_t                            axis_s3, axis_s4;
	logic                             anyout_s3, anyout_s4;
	logic                             inner_s3, inner_s4;
	logic [SQ_W-1:0]                  s_s4, dis_s4, s_s5;
	item_t                            item_s5;

	logic [AXES_MAX-1:0][COORD_W-1:0] absw_c, m_c, qin_c, d_c;
	logic [AXES_MAX-1:0]              neg_c, clamp_c, out_c;
	axis_t                            axis_c;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Per-axis magnitude, clamp offset and rounding-zone depth
	always_comb begin
		logic [CFG_W-1:0] t;
		logic [COORD_W:0] sum;
		for (int k = 0; k < AXES_MAX; k++) begin
			neg_c[k]   = w_s1[k][COORD_W-1];
			absw_c[k]  = neg_c[k] ? (~w_s1[k] + 1'b1) : w_s1[k];
			t          = inner_half(cfg.half_len[k], cfg.radius);
			clamp_c[k] = (k < AXES) && (absw_c[k] > {1'b0, t});
			m_c[k]     = clamp_c[k] ? absw_c[k] - {1'b0, t} : '0;
			out_c[k]   = (k < AXES) && (absw_c[k] > {1'b0, cfg.half_len[k]});
			sum        = {1'b0, absw_c[k]} + {2'b0, cfg.radius};
			qin_c[k]   = ((k < AXES) && (sum > {2'b0, cfg.half_len[k]}))
				? COORD_W'(sum - {2'b0, cfg.half_len[k]}) : '0;
			d_c[k]     = {1'b0, cfg.half_len[k]} - absw_c[k];
		end
	end

	// Nearest face; ties go to x, then y
	always_comb begin
		if (AXES > 2) begin
			if (d_s2[2] < d_s2[1]) begin
				axis_c = (d_s2[2] < d_s2[0]) ? AXIS_Z : AXIS_X;
			end else begin
				axis_c = (d_s2[1] < d_s2[0]) ? AXIS_Y : AXIS_X;
			end
		end else begin
			axis_c = (d_s2[1] < d_s2[0]) ? AXIS_Y : AXIS_X;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		w_s1 <= in_w;

		w_s2     <= w_s1;
		neg_s2   <= neg_c;
		clamp_s2 <= clamp_c;
		out_s2   <= out_c;
		m_s2     <= m_c;
		qin_s2   <= qin_c;
		d_s2     <= d_c;

		for (int k = 0; k < AXES_MAX; k++) begin
			msq_s3[k] <= m_s2[k] * m_s2[k];
			qsq_s3[k] <= qin_s2[k] * qin_s2[k];
		end
		rsq_s3    <= cfg.radius * cfg.radius;
		axis_s3   <= axis_c;
		anyout_s3 <= |out_s2;
		inner_s3  <= ~|clamp_s2;
		w_s3      <= w_s2;
		neg_s3    <= neg_s2;
		clamp_s3  <= clamp_s2;
		m_s3      <= m_s2;

		s_s4      <= msq_s3[0] + msq_s3[1] + msq_s3[2];
		dis_s4    <= qsq_s3[0] + qsq_s3[1] + qsq_s3[2];
		rsq_s4    <= rsq_s3;
		axis_s4   <= axis_s3;
		anyout_s4 <= anyout_s3;
		inner_s4  <= inner_s3;
		w_s4      <= w_s3;
		neg_s4    <= neg_s3;
		clamp_s4  <= clamp_s3;
		m_s4      <= m_s3;

		item_s5.w        <= w_s4;
		item_s5.neg      <= neg_s4;
		item_s5.clamped  <= clamp_s4;
		item_s5.m        <= m_s4;
		item_s5.in_box   <= !anyout_s4 && (dis_s4 <= {2'b0, rsq_s4});
		item_s5.in_inner <= inner_s4;
		item_s5.axis     <= axis_s4;
		s_s5             <= s_s4;
	end

	assign out_valid = valid_s5;
	assign out_item  = item_s5;
	assign out_s     = s_s5;

endmodule

`default_nettype wire

// File: src/rbpp_sqrt.sv
// Pipelined integer square root of the squared offset length, one root bit per stage.
// Depends on rbpp_pkg.
`default_nettype none

module rbpp_sqrt import rbpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  item_t             in_item,
	input  logic [SQ_W-1:0]   in_s,
	output logic              out_valid,
	output item_t             out_item,
	output logic [ROOT_W-1:0] out_root
);

	localparam int REM_W = ROOT_W + 2;

	logic                valid_s [ROOT_W];
	item_t               item_s  [ROOT_W];
	logic [REM_W-1:0]    rem_s   [ROOT_W];
	logic [ROOT_W-1:0]   root_s  [ROOT_W];
	logic [SQ_W-1:0]     sh_s    [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		logic              v_in;
		item_t             item_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SQ_W-1:0]   sh_in;
		logic [REM_W+1:0]  rem_nx, trial, diff;
		logic              ge;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign item_in = in_item;
			assign rem_in  = '0;
			assign root_in = '0;
			assign sh_in   = in_s;
		end else begin : g_next
			assign v_in    = valid_s[i-1];
			assign item_in = item_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign sh_in   = sh_s[i-1];
		end

		// Bring down two bits, try root*4+1
		assign rem_nx = {rem_in, sh_in[SQ_W-1 -: 2]};
		assign trial  = {2'b00, root_in, 2'b01};
		assign ge     = rem_nx >= trial;
		assign diff   = rem_nx - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			item_s[i] <= item_in;
			rem_s[i]  <= ge ? diff[REM_W-1:0] : rem_nx[REM_W-1:0];
			root_s[i] <= {root_in[ROOT_W-2:0], ge};
			sh_s[i]   <= {sh_in[SQ_W-3:0], 2'b00};
		end
	end

	assign out_valid = valid_s[ROOT_W-1];
	assign out_item  = item_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1];

endmodule

`default_nettype wire

// File: src/rbpp_div.sv
// Offset rescale: r*|v| plus half the length, then pipelined division by the length.
// Two product stages and one quotient bit per stage; depends on rbpp_pkg.
`default_nettype none

module rbpp_div import rbpp_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           in_valid,
	input  item_t                          in_item,
	input  logic [ROOT_W-1:0]              in_root,
	output logic                           out_valid,
	output item_t                          out_item,
	output logic [AXES_MAX-1:0][QUO_W-1:0] out_quo
);

	logic                             valid_s1, valid_s2;
	item_t                            item_s1, item_s2;
	logic [ROOT_W-1:0]                n_s1, n_s2;
	logic [AXES_MAX-1:0][PROD_W-1:0]  prod_s1, num_s2;

	logic                            valid_s [QUO_W];
	item_t                           item_s  [QUO_W];
	logic [ROOT_W-1:0]               n_s     [QUO_W];
	logic [AXES_MAX-1:0][ROOT_W-1:0] rem_s   [QUO_W];
	logic [AXES_MAX-1:0][QUO_W-1:0]  low_s   [QUO_W];
	logic [AXES_MAX-1:0][QUO_W-1:0]  quo_s   [QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Scale by the radius, then add half the length for rounding
	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		n_s1    <= (in_root == '0) ? ROOT_W'(1) : in_root;
		for (int k = 0; k < AXES_MAX; k++) begin
			prod_s1[k] <= cfg.radius * in_item.m[k];
		end
		item_s2 <= item_s1;
		n_s2    <= n_s1;
		for (int k = 0; k < AXES_MAX; k++) begin
			num_s2[k] <= prod_s1[k] + PROD_W'(n_s1[ROOT_W-1:1]);
		end
	end

	for (genvar j = 0; j < QUO_W; j++) begin : g_step
		logic                            v_in;
		item_t                           item_in;
		logic [ROOT_W-1:0]               n_in;
		logic [AXES_MAX-1:0][ROOT_W-1:0] rem_in;
		logic [AXES_MAX-1:0][QUO_W-1:0]  low_in, quo_in;

		if (j == 0) begin : g_first
			assign v_in    = valid_s2;
			assign item_in = item_s2;
			assign n_in    = n_s2;
			for (genvar k = 0; k < AXES_MAX; k++) begin : g_lane
				assign rem_in[k] = num_s2[k][PROD_W-1:QUO_W];
				assign low_in[k] = num_s2[k][QUO_W-1:0];
				assign quo_in[k] = '0;
			end
		end else begin : g_next
			assign v_in    = valid_s[j-1];
			assign item_in = item_s[j-1];
			assign n_in    = n_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign low_in  = low_s[j-1];
			assign quo_in  = quo_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else begin
				valid_s[j] <= v_in;
			end
		end

		// Shift in the next dividend bit and subtract where it fits
		always_ff @(posedge clk) begin
			logic [ROOT_W:0] x;
			logic            ge;
			item_s[j] <= item_in;
			n_s[j]    <= n_in;
			for (int k = 0; k < AXES_MAX; k++) begin
				x  = {rem_in[k], low_in[k][QUO_W-1]};
				ge = x >= {1'b0, n_in};
				rem_s[j][k] <= ge ? ROOT_W'(x - {1'b0, n_in}) : x[ROOT_W-1:0];
				low_s[j][k] <= {low_in[k][QUO_W-2:0], 1'b0};
				quo_s[j][k] <= {quo_in[k][QUO_W-2:0], ge};
			end
		end
	end

	assign out_valid = valid_s[QUO_W-1];
	assign out_item  = item_s[QUO_W-1];
	assign out_quo   = quo_s[QUO_W-1];

endmodule

`default_nettype wire

// File: src/rounded_box_point_projection_unit.sv
// Top level of the rounded box point projection unit: config port, pipeline, output stage.
// Depends on rbpp_pkg, rbpp_cfg, rbpp_front, rbpp_sqrt and rbpp_div.
//
//  channel   handshake              payload
//  input     start (busy held low)  point_x, point_y, point_z
//  result    done, one cycle        is_inside, surface_x, surface_y, surface_z
//  config    APB psel/penable       paddr, pwdata, prdata, pready
//
// One point enters every cycle; done rises once its result has passed through
// 71 register stages: 5 front stages, the 32 root-bit stages of the square root, 2 product
// and 31 quotient-bit stages of the divider, and the output register.
// busy is always low. Reset clears the valid bits and configuration registers to zero and so empties the pipeline.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`default_nettype none

module rounded_box_point_projection_unit import rbpp_pkg::*; #(
	parameter int DIMENSIONS = DIMENSIONS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	output logic                      done,
	output logic                      is_inside,
	output logic signed [COORD_W-1:0] surface_x,
	output logic signed [COORD_W-1:0] surface_y,
	output logic signed [COORD_W-1:0] surface_z,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready
);

	cfg_t                             cfg;
	logic                             f_valid, q_valid, d_valid;
	item_t                            f_item, q_item, d_item;
	logic [SQ_W-1:0]                  f_s;
	logic [ROOT_W-1:0]                q_root;
	logic [AXES_MAX-1:0][QUO_W-1:0]   d_quo;
	logic [AXES_MAX-1:0][COORD_W-1:0] p_c;
	logic [AXES_MAX-1:0][COORD_W-1:0] p_q;
	logic                             done_q, in_box_q;

	assign busy = 1'b0;

	rbpp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbpp_front #(.DIMENSIONS(DIMENSIONS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (start && !busy),
		.in_w      ({point_z, point_y, point_x}),
		.out_valid (f_valid),
		.out_item  (f_item),
		.out_s     (f_s)
	);

	rbpp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_item   (f_item),
		.in_s      (f_s),
		.out_valid (q_valid),
		.out_item  (q_item),
		.out_root  (q_root)
	);

	rbpp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (q_valid),
		.in_item   (q_item),
		.in_root   (q_root),
		.out_valid (d_valid),
		.out_item  (d_item),
		.out_quo   (d_quo)
	);

	// Final coordinate: face snap, or clamp plus scaled offset with saturation; unclamped axes keep the input
	always_comb begin
		logic [CFG_W-1:0]   t;
		logic [COORD_W-1:0] mag;
		logic [COORD_W-1:0] len;
		for (int k = 0; k < AXES_MAX; k++) begin
			t   = inner_half(cfg.half_len[k], cfg.radius);
			mag = {1'b0, t} + {1'b0, d_quo[k]};
			len = {1'b0, cfg.half_len[k]};
			if (d_item.in_inner) begin
				if (d_item.axis == axis_t'(k)) begin
					p_c[k] = d_item.neg[k] ? (~len + 1'b1) : len;
				end else begin
					p_c[k] = d_item.w[k];
				end
			end else if (d_item.clamped[k]) begin
				if (d_item.neg[k]) begin
					p_c[k] = (mag > {1'b1, {(COORD_W-1){1'b0}}})
						? {1'b1, {(COORD_W-1){1'b0}}} : (~mag + 1'b1);
				end else begin
					p_c[k] = (mag > {1'b0, {(COORD_W-1){1'b1}}})
						? {1'b0, {(COORD_W-1){1'b1}}} : mag;
				end
			end else begin
				p_c[k] = d_item.w[k];
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		in_box_q <= d_item.in_box;
		p_q      <= p_c;
	end

	assign done      = done_q;
	assign is_inside = in_box_q;
	assign surface_x = p_q[0];
	assign surface_y = p_q[1];
	assign surface_z = p_q[2];

endmodule

`default_nettype wire

// File: verif/rbpp_checker.sv
// Result checker for the rounded box point projection unit: tracks register writes,
// predicts every accepted point and compares the results in order. Depends on rbpp_pkg.
`timescale 1ns / 100ps

module rbpp_checker import rbpp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	input  logic                      done,
	input  logic                      is_inside,
	input  logic signed [COORD_W-1:0] surface_x,
	input  logic signed [COORD_W-1:0] surface_y,
	input  logic signed [COORD_W-1:0] surface_z,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output int                        pending,
	output int                        checked,
	output int                        errors
);

	typedef struct packed {
		logic                             in_box;
		logic [AXES_MAX-1:0][COORD_W-1:0] surf;
	} surface_t;

	logic [CFG_W-1:0] half_len_q [AXES_MAX];
	logic [CFG_W-1:0] radius_q;
	surface_t         expected_q [$];

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned s);
		longint unsigned res = 0;
		longint unsigned b = 64'h1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [COORD_W-1:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[COORD_W-1:0];
	endfunction

	// Inside test, then either face snap or clamp and rescale of the offset
	function automatic surface_t project_point(input logic [AXES_MAX-1:0][COORD_W-1:0] pt);
		longint w [AXES_MAX];
		longint p [AXES_MAX];
		longint len [AXES_MAX];
		longint t [AXES_MAX];
		longint r, a, d0, d1, d2, v;
		longint unsigned dis, s, n, m, q;
		bit in_inner, in_box;
		axis_t axis;
		surface_t res;
		r = longint'(radius_q);
		in_inner = 1;
		in_box = 1;
		dis = 0;
		for (int k = 0; k < AXES_MAX; k++) begin
			w[k] = longint'($signed(pt[k]));
			p[k] = w[k];
			len[k] = longint'(half_len_q[k]);
			t[k] = len[k] > r ? len[k] - r : 0;
		end
		for (int k = 0; k < AXES_MAX; k++) begin
			a = mag(w[k]) - len[k];
			if (a > 0)
				in_box = 0;
			else if (a + r > 0)
				dis += longint'(a + r) * longint'(a + r);
		end
		if (in_box && dis > longint'(r) * longint'(r))
			in_box = 0;
		for (int k = 0; k < AXES_MAX; k++) begin
			if (mag(w[k]) > t[k]) begin
				p[k] = w[k] < 0 ? -t[k] : t[k];
				in_inner = 0;
			end
		end
		if (in_inner) begin
			// Snap to the nearest face; ties go to x, then y
			d0 = len[0] - mag(w[0]);
			d1 = len[1] - mag(w[1]);
			d2 = len[2] - mag(w[2]);
			if (d2 < d1)
				axis = (d2 < d0) ? AXIS_Z : AXIS_X;
			else
				axis = (d1 < d0) ? AXIS_Y : AXIS_X;
			p[axis] = w[axis] < 0 ? -len[axis] : len[axis];
		end else begin
			s = 0;
			for (int k = 0; k < AXES_MAX; k++) begin
				m = mag(w[k] - p[k]);
				s += m * m;
			end
			n = root_floor(s);
			if (n == 0)
				n = 1;
			for (int k = 0; k < AXES_MAX; k++) begin
				v = w[k] - p[k];
				m = mag(v);
				q = (longint'(r) * m + n / 2) / n;
				if (v < 0)
					p[k] -= longint'(q);
				else
					p[k] += longint'(q);
			end
		end
		res.in_box = in_box;
		for (int k = 0; k < AXES_MAX; k++)
			res.surf[k] = clip32(p[k]);
		return res;
	endfunction

	// Track register writes and queue a prediction per accepted point
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AXES_MAX; k++)
				half_len_q[k] <= '0;
			radius_q <= '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_HALF_X: half_len_q[0] <= pwdata[CFG_W-1:0];
					REG_HALF_Y: half_len_q[1] <= pwdata[CFG_W-1:0];
					REG_HALF_Z: half_len_q[2] <= pwdata[CFG_W-1:0];
					REG_RADIUS: radius_q      <= pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				expected_q.push_back(project_point({point_z, point_y, point_x}));
		end
	end

	// Compare each result transaction with the oldest prediction
	initial begin
		checked = 0;
		errors = 0;
	end

	always @(posedge clk) begin
		surface_t exp_res;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected result transaction at %0t", $realtime);
			end else begin
				exp_res = expected_q.pop_front();
				checked++;
				if (exp_res.in_box !== is_inside || exp_res.surf[0] !== surface_x ||
						exp_res.surf[1] !== surface_y || exp_res.surf[2] !== surface_z) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: result %0d expected in=%0b (%h %h %h) got in=%0b (%h %h %h)",
							checked, exp_res.in_box, exp_res.surf[0], exp_res.surf[1],
							exp_res.surf[2], is_inside, surface_x, surface_y, surface_z);
				end
			end
		end
	end

	assign pending = expected_q.size();

endmodule

// File: verif/tb.sv
// Testbench top for the rounded box point projection unit: clock, reset, APB writes
// and point stimulus, verdict. Depends on rbpp_pkg, rbpp_checker and the unit itself.
`timescale 1ns / 100ps

module tb;
	import rbpp_pkg::*;

	localparam int LATENCY     = 71;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 10;
	localparam int PER_PHASE   = 153;

	logic                      clk = 0;
	logic                      arst_n = 0;
	logic                      start = 0;
	logic                      busy;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic signed [COORD_W-1:0] point_z = '0;
	logic                      done;
	logic                      is_inside;
	logic signed [COORD_W-1:0] surface_x, surface_y, surface_z;
	logic                      psel = 0;
	logic                      penable = 0;
	logic                      pwrite = 0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [DATA_W-1:0]         pwdata = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	int                        pending, checked, errors;
	int                        cycles = 0;
	longint unsigned           box_len [AXES_MAX];
	longint unsigned           box_rad;

	always #1 clk = ~clk;

	rounded_box_point_projection_unit dut (.*);

	rbpp_checker u_checker (.*);

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic set_box(input logic [DATA_W-1:0] lx, ly, lz, rad);
		write_reg(REG_HALF_X, lx);
		write_reg(REG_HALF_Y, ly);
		write_reg(REG_HALF_Z, lz);
		write_reg(REG_RADIUS, rad);
		box_len[0] = lx[CFG_W-1:0];
		box_len[1] = ly[CFG_W-1:0];
		box_len[2] = lz[CFG_W-1:0];
		box_rad = rad[CFG_W-1:0];
	endtask

	// Hold start low until every result is back and the pipeline has drained
	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	// Drive one point, wait for acceptance, then drop start and idle for the given gap
	task automatic send_point(input logic [COORD_W-1:0] x, y, z, input int gap);
		@(negedge clk);
		start <= 1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		if (gap > 0) begin
			@(negedge clk);
			start <= 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic logic [COORD_W-1:0] clip_coord(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[COORD_W-1:0];
	endfunction

	// Coordinates mostly around the box, some on faces and corners, some anywhere
	function automatic logic [COORD_W-1:0] pick_coord(input int k);
		longint unsigned span;
		longint v;
		int sel;
		sel = $urandom_range(0, 9);
		span = box_len[k] + 2 * box_rad + 16;
		if (sel < 6) begin
			v = longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
		end else if (sel < 8) begin
			case ($urandom_range(0, 3))
				0: v = box_len[k];
				1: v = box_len[k] > box_rad ? box_len[k] - box_rad : 0;
				2: v = 0;
				default: v = box_len[k] + 1;
			endcase
			if ($urandom_range(0, 1))
				v = -v;
		end else begin
			return $urandom;
		end
		return clip_coord(v);
	endfunction

	function automatic int pick_gap(input bit idle_on);
		int sel;
		sel = $urandom_range(0, 19);
		if (!idle_on || sel < 12)
			return 0;
		if (sel < 19)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic random_points(input int count, input bit idle_on);
		logic [COORD_W-1:0] x, y, z;
		for (int i = 0; i < count; i++) begin
			x = pick_coord(0);
			y = pick_coord(1);
			z = pick_coord(2);
			// Equal magnitudes on all axes exercise the face tie breaks
			if ($urandom_range(0, 9) == 0) begin
				y = $urandom_range(0, 1) ? x : -x;
				z = $urandom_range(0, 1) ? x : -x;
			end
			send_point(x, y, z, pick_gap(idle_on));
		end
	endtask

	initial begin
		logic [DATA_W-1:0] lx, ly, lz, rad;
		box_len[0] = 0;
		box_len[1] = 0;
		box_len[2] = 0;
		box_rad = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ;
				1: set_box(32'h5_0000, 32'h3_0000, 32'h4_0000, 32'h1_0000);
				2: set_box(32'h2_0000, 32'h2_0000, 32'h2_0000, 32'h0);
				3: set_box(32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h3_0000);
				4: set_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				5: set_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
				default: begin
					lx = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40_0000);
					ly = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40_0000);
					lz = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40_0000);
					rad = $urandom_range(0, 3) == 0 ? $urandom
						: $urandom_range(0, 32'h20_0000);
					set_box(lx, ly, lz, rad);
				end
			endcase

			// Extremes, faces, ties, corners and edges on a small box
			if (ph == 1) begin
				send_point(32'h0, 32'h0, 32'h0, 0);
				send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
				send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
				send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1);
				send_point(32'hFFFF_FFFF, 32'h0, 32'h0, 0);
				send_point(32'h5_0000, 32'h0, 32'h0, 0);
				send_point(-32'sh5_0000, 32'h0, 32'h0, 2);
				send_point(32'h0, 32'h3_0000, 32'h0, 0);
				send_point(32'h0, 32'h0, -32'sh4_0000, 0);
				send_point(32'h4_0000, 32'h2_0000, 32'h3_0000, 0);
				send_point(32'h4_0000, 32'h2_0000, -32'sh3_0000, 0);
				send_point(32'h6_0000, 32'h4_0000, 32'h5_0000, 0);
				send_point(-32'sh6_0000, -32'sh4_0000, -32'sh5_0000, 5);
				send_point(32'h5_8000, 32'h3_8000, 32'h0, 0);
				send_point(32'h5_0001, 32'h0, 32'h0, 0);
				send_point(32'h4_8000, 32'h2_8000, 32'h3_8000, 0);
				send_point(32'h4_B505, 32'h2_B505, 32'h0, 0);
				send_point(32'h0, 32'h0, 32'h7FFF_FFFF, 0);
			end
			if (ph == 2) begin
				send_point(32'h0, 32'h0, 32'h0, 0);
				send_point(32'h1_0000, 32'h1_0000, 32'h1_0000, 0);
				send_point(-32'sh1_0000, 32'h1_0000, -32'sh1_0000, 0);
				send_point(32'h0, 32'h1_0000, 32'h1_0000, 0);
			end
			random_points(PER_PHASE, ph % 3 != 0);
			drain();
		end

		$display("Checked %0d projected points across %0d box settings,", checked, PHASES);
		$display("covering radius zero, radius above a half length and full-scale boxes.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
src/rbpp_pkg.sv
src/rbpp_cfg.sv
src/rbpp_front.sv
src/rbpp_sqrt.sv
src/rbpp_div.sv
src/rounded_box_point_projection_unit.sv
verif/rbpp_checker.sv
verif/tb.sv
